>>> rtl/tcce_pkg.sv
`timescale 1ns / 1ps

package tcce_pkg;

	localparam int CHAR_W    = 8;
	localparam int COORD_W   = 8;
	localparam int GLYPH_W   = 7;
	localparam int COLOR_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	localparam int FIFO_DEPTH = 4;

	// character codes
	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;
	localparam logic [CHAR_W-1:0] PRINT_LOW      = 8'd32;
	localparam logic [CHAR_W-1:0] PRINT_HIGH     = 8'd126;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd4;

	// reset values of the configuration registers
	localparam logic [COORD_W-1:0] RST_COLUMNS   = 8'd80;
	localparam logic [COORD_W-1:0] RST_TEXT_ROWS = 8'd25;
	localparam logic [COLOR_W-1:0] RST_FG_COLOR  = 24'hC0C0C0;
	localparam logic [COLOR_W-1:0] RST_BG_COLOR  = 24'h000000;

	// result command codes
	localparam logic CMD_DRAW   = 1'b0;
	localparam logic CMD_SCROLL = 1'b1;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_NEWLINE,
		OP_RETURN,
		OP_TAB,
		OP_BACKSPACE,
		OP_PRINT
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [GLYPH_W-1:0] glyph;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qport_t;

	typedef struct packed {
		logic [COORD_W-1:0] columns;
		logic [COORD_W-1:0] text_rows;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
	} geom_cfg_t;

	typedef struct packed {
		logic               command;
		logic [COORD_W-1:0] cell_column;
		logic [COORD_W-1:0] cell_row;
		logic [GLYPH_W-1:0] glyph;
		logic [COLOR_W-1:0] draw_fg;
		logic [COLOR_W-1:0] draw_bg;
		logic               last;
	} res_t;

endpackage

>>> rtl/tcce_char_if.sv
`timescale 1ns / 1ps

interface tcce_char_if import tcce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

>>> rtl/tcce_cmd_if.sv
`timescale 1ns / 1ps

interface tcce_cmd_if import tcce_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               command;
	logic [COORD_W-1:0] cell_column;
	logic [COORD_W-1:0] cell_row;
	logic [GLYPH_W-1:0] glyph;
	logic [COLOR_W-1:0] draw_fg;
	logic [COLOR_W-1:0] draw_bg;
	logic               last;

	modport source (output valid, output command, output cell_column, output cell_row,
		output glyph, output draw_fg, output draw_bg, output last, input ready);
	modport sink (input valid, input command, input cell_column, input cell_row,
		input glyph, input draw_fg, input draw_bg, input last, output ready);
endinterface

>>> rtl/tcce_cfg_if.sv
`timescale 1ns / 1ps

interface tcce_cfg_if import tcce_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output reg_index, output data, input ready);
	modport sink (input valid, input reg_index, input data, output ready);
endinterface

>>> rtl/tcce_front.sv
`timescale 1ns / 1ps

module tcce_front import tcce_pkg::*; (
	tcce_char_if.sink chars,
	input  logic      display_enable,
	input  logic      push_ready,
	output qport_t    push
);

	item_t item;

	always_comb begin
		item.op    = OP_NONE;
		item.glyph = chars.char_code[GLYPH_W-1:0];
		unique case (chars.char_code)
			CODE_NEWLINE:   item.op = OP_NEWLINE;
			CODE_RETURN:    item.op = OP_RETURN;
			CODE_BACKSPACE: item.op = OP_BACKSPACE;
			CODE_TAB: begin
				item.op    = OP_TAB;
				item.glyph = CODE_SPACE[GLYPH_W-1:0];
			end
			default: begin
				if (chars.char_code >= PRINT_LOW && chars.char_code <= PRINT_HIGH)
					item.op = OP_PRINT;
			end
		endcase
	end

	// drop codes with no effect and everything while the display is off
	assign chars.ready = push_ready;
	assign push.valid  = chars.valid && push_ready && display_enable && (item.op != OP_NONE);
	assign push.item   = item;

endmodule

>>> rtl/tcce_fifo.sv
`timescale 1ns / 1ps

module tcce_fifo import tcce_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  qport_t push,
	output logic   push_ready,
	output qport_t head,
	input  logic   pop
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	item_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(FIFO_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/tcce_back.sv
`timescale 1ns / 1ps

module tcce_back import tcce_pkg::*; #(
	parameter int TAB_SPACES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  geom_cfg_t geom,
	input  qport_t    head,
	output logic      pop,
	tcce_cmd_if.source cmds
);

	localparam int SPW = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

	typedef enum logic [1:0] {
		PH_MAIN,
		PH_SCROLL,
		PH_BS_OLD
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [COORD_W-1:0] col_q, col_n, row_q, row_n;
	logic [COORD_W-1:0] old_col_q, old_col_n, old_row_q, old_row_n;
	logic [SPW-1:0]     spaces_q, spaces_n;
	res_t               res_q, res_n;
	logic               out_valid_q;

	logic [COORD_W-1:0] eff_cols, eff_rows;
	logic [COORD_W:0]   col_inc, row_inc;
	logic               wrap, row_over, last_space, moved;
	logic               need_emit, can_emit, fire;
	res_t               draw_res, scroll_res;

	assign eff_cols   = (geom.columns == '0) ? COORD_W'(1) : geom.columns;
	assign eff_rows   = (geom.text_rows == '0) ? COORD_W'(1) : geom.text_rows;
	assign col_inc    = {1'b0, col_q} + 1'b1;
	assign row_inc    = {1'b0, row_q} + 1'b1;
	assign wrap       = col_inc >= {1'b0, eff_cols};
	assign row_over   = row_inc >= {1'b0, eff_rows};
	assign last_space = (head.item.op == OP_TAB) ? (spaces_q == SPW'(TAB_SPACES - 1)) : 1'b1;
	assign moved      = (col_q != '0) || (row_q != '0);
	assign can_emit   = !out_valid_q || cmds.ready;
	assign fire       = head.valid && (!need_emit || can_emit);

	always_comb begin
		scroll_res         = '0;
		scroll_res.command = CMD_SCROLL;
		draw_res           = '0;
		draw_res.command   = CMD_DRAW;
		draw_res.draw_fg   = geom.fg;
		draw_res.draw_bg   = geom.bg;

		phase_n   = phase_q;
		col_n     = col_q;
		row_n     = row_q;
		old_col_n = old_col_q;
		old_row_n = old_row_q;
		spaces_n  = spaces_q;
		res_n     = draw_res;
		need_emit = 1'b0;
		pop       = 1'b0;

		unique case (phase_q)
			PH_MAIN: begin
				case (head.item.op)
					OP_PRINT, OP_TAB: begin
						need_emit         = 1'b1;
						res_n.cell_column = col_q;
						res_n.cell_row    = row_q;
						res_n.glyph       = head.item.glyph;
						res_n.last        = last_space;
						if (wrap) begin
							col_n = '0;
							if (row_over) begin
								row_n      = eff_rows - 1'b1;
								phase_n    = PH_SCROLL;
								res_n.last = 1'b0;
							end else begin
								row_n = row_inc[COORD_W-1:0];
							end
						end else begin
							col_n = col_inc[COORD_W-1:0];
						end
						if (!(wrap && row_over)) begin
							pop      = last_space;
							spaces_n = last_space ? '0 : spaces_q + 1'b1;
						end
					end
					OP_NEWLINE: begin
						col_n = '0;
						pop   = 1'b1;
						if (row_over) begin
							need_emit  = 1'b1;
							res_n      = scroll_res;
							res_n.last = 1'b1;
							row_n      = eff_rows - 1'b1;
						end else begin
							row_n = row_inc[COORD_W-1:0];
						end
					end
					OP_RETURN: begin
						col_n = '0;
						pop   = 1'b1;
					end
					OP_BACKSPACE: begin
						need_emit = 1'b1;
						old_col_n = col_q;
						old_row_n = row_q;
						if (col_q != '0) begin
							col_n = col_q - 1'b1;
						end else if (row_q != '0) begin
							row_n = row_q - 1'b1;
							col_n = eff_cols - 1'b1;
						end
						res_n.cell_column = col_n;
						res_n.cell_row    = row_n;
						res_n.glyph       = CODE_SPACE[GLYPH_W-1:0];
						res_n.last        = !moved;
						if (moved)
							phase_n = PH_BS_OLD;
						else
							pop = 1'b1;
					end
					default: pop = 1'b1;
				endcase
			end
			PH_SCROLL: begin
				need_emit  = 1'b1;
				res_n      = scroll_res;
				res_n.last = last_space;
				phase_n    = PH_MAIN;
				pop        = last_space;
				spaces_n   = last_space ? '0 : spaces_q + 1'b1;
			end
			PH_BS_OLD: begin
				need_emit         = 1'b1;
				res_n.cell_column = old_col_q;
				res_n.cell_row    = old_row_q;
				res_n.glyph       = CODE_SPACE[GLYPH_W-1:0];
				res_n.last        = 1'b1;
				phase_n           = PH_MAIN;
				pop               = 1'b1;
			end
			default: phase_n = PH_MAIN;
		endcase

		if (!fire)
			pop = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAIN;
			col_q       <= '0;
			row_q       <= '0;
			old_col_q   <= '0;
			old_row_q   <= '0;
			spaces_q    <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q   <= phase_n;
				col_q     <= col_n;
				row_q     <= row_n;
				old_col_q <= old_col_n;
				old_row_q <= old_row_n;
				spaces_q  <= spaces_n;
			end
			if (fire && need_emit) begin
				res_q       <= res_n;
				out_valid_q <= 1'b1;
			end else if (cmds.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cmds.valid       = out_valid_q;
	assign cmds.command     = res_q.command;
	assign cmds.cell_column = res_q.cell_column;
	assign cmds.cell_row    = res_q.cell_row;
	assign cmds.glyph       = res_q.glyph;
	assign cmds.draw_fg     = res_q.draw_fg;
	assign cmds.draw_bg     = res_q.draw_bg;
	assign cmds.last        = res_q.last;

endmodule

>>> rtl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
// Text console cursor engine: turns a stream of character bytes into draw-glyph
// and scroll-up commands while tracking the cursor column and row.
// Channels: chars (sink) takes one character byte per transfer; cmds (source)
// gives one command per transfer, with last set on the final command of each
// character; cfg (sink) writes geometry, colours and the display enable, and is
// always ready. Write cfg only while the block is idle.
// The first command of a character is registered in the queue and then in the
// output register before it is offered on cmds. Throughput: one command per
// cycle on cmds while cmds is ready; the back end handles one character at a
// time and gives one command for a plain print, two for a wrapping print that
// scrolls or a backspace that moves, up to 2*TAB_SPACES (8 by default) for a
// tab. The front accepts one character per cycle while the four-entry queue has
// room, so the command sequencer is the limit on sustained rate.
// Reset: the cursor goes to column 0, row 0; registers take their defaults
// (80 columns, 25 rows, grey on black, display on); queue and output empty.
// When cmds stalls, the output register holds its command, the sequencer
// stops, the queue fills and then chars is back-pressured.
module text_console_cursor_engine import tcce_pkg::*; #(
	parameter int TAB_SPACES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	tcce_char_if.sink  chars,
	tcce_cmd_if.source cmds,
	tcce_cfg_if.sink   cfg
);

	logic [COORD_W-1:0] columns_q;
	logic [COORD_W-1:0] text_rows_q;
	logic [COLOR_W-1:0] fg_color_q;
	logic [COLOR_W-1:0] bg_color_q;
	logic               display_enable_q;

	geom_cfg_t geom;
	qport_t    push;
	qport_t    head;
	logic      push_ready;
	logic      pop;

	// configuration registers: always accept, ignore indexes beyond the list
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q        <= RST_COLUMNS;
			text_rows_q      <= RST_TEXT_ROWS;
			fg_color_q       <= RST_FG_COLOR;
			bg_color_q       <= RST_BG_COLOR;
			display_enable_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_COLUMNS:   columns_q        <= cfg.data[COORD_W-1:0];
				REG_TEXT_ROWS: text_rows_q      <= cfg.data[COORD_W-1:0];
				REG_FG_COLOR:  fg_color_q       <= cfg.data[COLOR_W-1:0];
				REG_BG_COLOR:  bg_color_q       <= cfg.data[COLOR_W-1:0];
				REG_ENABLE:    display_enable_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign geom.columns   = columns_q;
	assign geom.text_rows = text_rows_q;
	assign geom.fg        = fg_color_q;
	assign geom.bg        = bg_color_q;

	// front: classify each byte, drop those with no effect
	tcce_front u_front (
		.chars          (chars),
		.display_enable (display_enable_q),
		.push_ready     (push_ready),
		.push           (push)
	);

	// queue between classification and command sequencing
	tcce_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	// back: cursor state and one command per cycle, while cmds is ready, into the output register
	tcce_back #(
		.TAB_SPACES (TAB_SPACES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.geom   (geom),
		.head   (head),
		.pop    (pop),
		.cmds   (cmds)
	);

endmodule

>>> tb/sv/cursor_cmd_checker.sv
`timescale 1ns / 1ps

// Watches the three channels, keeps a shadow of the registers and the cursor,
// predicts the commands of every accepted character and compares them in order.
module cursor_cmd_checker import tcce_pkg::*; #(
	parameter int TAB_SPACES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	input  logic                 char_ready,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic                 cmd_valid,
	input  logic                 cmd_ready,
	input  res_t                 cmd_seen,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   errors,
	output int                   outstanding,
	output int                   draws_checked,
	output int                   scrolls_checked
);
	localparam int REPORT_LIMIT = 40;

	logic [COORD_W-1:0] grid_columns;
	logic [COORD_W-1:0] grid_rows;
	logic [COLOR_W-1:0] fg_color;
	logic [COLOR_W-1:0] bg_color;
	logic               display_on;
	int unsigned        cursor_col;
	int unsigned        cursor_row;
	res_t               expected_cmds[$];
	int                 reports;

	function automatic op_t classify(input logic [CHAR_W-1:0] code);
		if (code == CODE_NEWLINE)
			return OP_NEWLINE;
		if (code == CODE_RETURN)
			return OP_RETURN;
		if (code == CODE_TAB)
			return OP_TAB;
		if (code == CODE_BACKSPACE)
			return OP_BACKSPACE;
		if (code >= PRINT_LOW && code <= PRINT_HIGH)
			return OP_PRINT;
		return OP_NONE;
	endfunction

	// a zero in either geometry register behaves as one
	function automatic int unsigned cols_in_use();
		return (grid_columns == '0) ? 1 : grid_columns;
	endfunction

	function automatic int unsigned rows_in_use();
		return (grid_rows == '0) ? 1 : grid_rows;
	endfunction

	function automatic void expect_cmd(input logic cmd, input int unsigned col,
		input int unsigned row, input logic [GLYPH_W-1:0] glyph);
		res_t r;
		r = '0;
		r.command = cmd;
		if (cmd == CMD_DRAW) begin
			r.cell_column = COORD_W'(col);
			r.cell_row    = COORD_W'(row);
			r.glyph       = glyph;
			r.draw_fg     = fg_color;
			r.draw_bg     = bg_color;
		end
		expected_cmds.push_back(r);
	endfunction

	function automatic void line_feed();
		cursor_col = 0;
		if (cursor_row + 1 >= rows_in_use()) begin
			expect_cmd(CMD_SCROLL, 0, 0, '0);
			cursor_row = rows_in_use() - 1;
		end else begin
			cursor_row = cursor_row + 1;
		end
	endfunction

	function automatic void put_glyph(input logic [GLYPH_W-1:0] glyph);
		expect_cmd(CMD_DRAW, cursor_col, cursor_row, glyph);
		if (cursor_col + 1 >= cols_in_use())
			line_feed();
		else
			cursor_col = cursor_col + 1;
	endfunction

	// step back, erase the new cell, then the old one if the cursor moved
	function automatic void rub_out();
		int unsigned old_col;
		int unsigned old_row;
		old_col = cursor_col;
		old_row = cursor_row;
		if (cursor_col > 0) begin
			cursor_col = cursor_col - 1;
		end else if (cursor_row > 0) begin
			cursor_row = cursor_row - 1;
			cursor_col = cols_in_use() - 1;
		end
		expect_cmd(CMD_DRAW, cursor_col, cursor_row, GLYPH_W'(CODE_SPACE));
		if (old_col != cursor_col || old_row != cursor_row)
			expect_cmd(CMD_DRAW, old_col, old_row, GLYPH_W'(CODE_SPACE));
	endfunction

	function automatic void predict_commands(input logic [CHAR_W-1:0] code);
		int first;
		first = expected_cmds.size();
		if (!display_on)
			return;
		case (classify(code))
			OP_NEWLINE:   line_feed();
			OP_RETURN:    cursor_col = 0;
			OP_TAB:       for (int i = 0; i < TAB_SPACES; i++) put_glyph(GLYPH_W'(CODE_SPACE));
			OP_BACKSPACE: rub_out();
			OP_PRINT:     put_glyph(GLYPH_W'(code));
			default:      ;
		endcase
		if (expected_cmds.size() > first)
			expected_cmds[expected_cmds.size() - 1].last = 1'b1;
	endfunction

	function automatic void note_error(input string what, input logic [31:0] want,
		input logic [31:0] got);
		errors++;
		if (reports < REPORT_LIMIT)
			$display("t=%0t ns: %s, expected 'h%0h, actual 'h%0h", $time, what, want, got);
		else if (reports == REPORT_LIMIT)
			$display("t=%0t ns: further mismatches are counted but not shown", $time);
		reports++;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got)
			note_error({name, " mismatch"}, want, got);
	endfunction

	function automatic void check_cmd();
		res_t want;
		if (expected_cmds.size() == 0) begin
			note_error("command with no character behind it (command/glyph)",
				32'(cmd_seen.command), 32'(cmd_seen.glyph));
			return;
		end
		want = expected_cmds.pop_front();
		compare_field("command",     32'(want.command),     32'(cmd_seen.command));
		compare_field("cell_column", 32'(want.cell_column), 32'(cmd_seen.cell_column));
		compare_field("cell_row",    32'(want.cell_row),    32'(cmd_seen.cell_row));
		compare_field("glyph",       32'(want.glyph),       32'(cmd_seen.glyph));
		compare_field("draw_fg",     32'(want.draw_fg),     32'(cmd_seen.draw_fg));
		compare_field("draw_bg",     32'(want.draw_bg),     32'(cmd_seen.draw_bg));
		compare_field("last",        32'(want.last),        32'(cmd_seen.last));
		if (want.command == CMD_SCROLL)
			scrolls_checked++;
		else
			draws_checked++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns    = RST_COLUMNS;
			grid_rows       = RST_TEXT_ROWS;
			fg_color        = RST_FG_COLOR;
			bg_color        = RST_BG_COLOR;
			display_on      = 1'b1;
			cursor_col      = 0;
			cursor_row      = 0;
			expected_cmds.delete();
			errors          = 0;
			reports         = 0;
			draws_checked   = 0;
			scrolls_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COLUMNS:   grid_columns = cfg_data[COORD_W-1:0];
					REG_TEXT_ROWS: grid_rows    = cfg_data[COORD_W-1:0];
					REG_FG_COLOR:  fg_color     = cfg_data[COLOR_W-1:0];
					REG_BG_COLOR:  bg_color     = cfg_data[COLOR_W-1:0];
					REG_ENABLE:    display_on   = cfg_data[0];
					default:       ;
				endcase
			end
			if (cmd_valid && cmd_ready)
				check_cmd();
			if (char_valid && char_ready)
				predict_commands(char_code);
		end
		outstanding = expected_cmds.size();
	end

endmodule

>>> tb/sv/text_console_cursor_engine_tb.sv
`timescale 1ns / 1ps

module text_console_cursor_engine_tb import tcce_pkg::*;;

	localparam int TAB_COUNT    = 4;
	localparam int DRAIN_CYCLES = 12;  // queue depth plus pipeline, with margin
	localparam int TAIL_CYCLES  = 20;
	localparam int LONG_HOLD    = 80;  // long output stall, in cycles
	localparam int STEADY_ITEMS = 30;  // items offered without gaps under that stall

	typedef enum int {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_PULSED
	} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	int errors;
	int outstanding;
	int draws_checked;
	int scrolls_checked;
	int items_sent;
	int settings_run;
	int stall_requests;
	int stall_served;

	logic [CHAR_W-1:0] directed_codes[$];

	tcce_char_if char_bus ();
	tcce_cmd_if  cmd_bus ();
	tcce_cfg_if  cfg_bus ();

	text_console_cursor_engine #(
		.TAB_SPACES(TAB_COUNT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (char_bus),
		.cmds  (cmd_bus),
		.cfg   (cfg_bus)
	);

	cursor_cmd_checker #(
		.TAB_SPACES(TAB_COUNT)
	) cmd_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_bus.valid),
		.char_ready     (char_bus.ready),
		.char_code      (char_bus.char_code),
		.cmd_valid      (cmd_bus.valid),
		.cmd_ready      (cmd_bus.ready),
		.cmd_seen       (res_t'({cmd_bus.command, cmd_bus.cell_column, cmd_bus.cell_row,
			cmd_bus.glyph, cmd_bus.draw_fg, cmd_bus.draw_bg, cmd_bus.last})),
		.cfg_valid      (cfg_bus.valid),
		.cfg_ready      (cfg_bus.ready),
		.cfg_index      (cfg_bus.reg_index),
		.cfg_data       (cfg_bus.data),
		.errors         (errors),
		.outstanding    (outstanding),
		.draws_checked  (draws_checked),
		.scrolls_checked(scrolls_checked)
	);

	always #10 clk = ~clk;

	// Pick a character: mostly printable, with a fair share of the control
	// codes and some raw bytes across the whole range as noise.
	function automatic logic [CHAR_W-1:0] random_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 52)
			return CHAR_W'($urandom_range(PRINT_LOW, PRINT_HIGH));
		if (pick < 62)
			return CODE_NEWLINE;
		if (pick < 70)
			return CODE_TAB;
		if (pick < 81)
			return CODE_BACKSPACE;
		if (pick < 86)
			return CODE_RETURN;
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// Offer one character and hold it until the transfer; return at the
	// following falling edge with valid still high, so the caller decides
	// whether the next item follows straight on or the line drops.
	task automatic send_char(input logic [CHAR_W-1:0] code);
		char_bus.valid     <= 1'b1;
		char_bus.char_code <= code;
		do @(posedge clk); while (!char_bus.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Same contract for a register write: valid is left high on return.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] value);
		cfg_bus.valid     <= 1'b1;
		cfg_bus.reg_index <= idx;
		cfg_bus.data      <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
	endtask

	// Wait for every predicted command, then let any result-free characters
	// still queued inside the block drain before touching the registers.
	task automatic wait_idle();
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Geometry goes in with junk in the unused upper data bits.
	task automatic program_geometry(input logic [COORD_W-1:0] cols,
		input logic [COORD_W-1:0] rows, input logic [COLOR_W-1:0] fg,
		input logic [COLOR_W-1:0] bg);
		write_reg(REG_COLUMNS, {16'($urandom_range(0, 16'hFFFF)), cols});
		write_reg(REG_TEXT_ROWS, {16'($urandom_range(0, 16'hFFFF)), rows});
		write_reg(REG_FG_COLOR, fg);
		write_reg(REG_BG_COLOR, bg);
		cfg_bus.valid <= 1'b0;
		settings_run++;
	endtask

	// Random characters in bursts of random length with random gaps; the
	// first 'steady' items go out back to back.
	task automatic send_stream(input int count, input int steady);
		int burst;
		burst = $urandom_range(1, 16);
		for (int i = 0; i < count; i++) begin
			send_char(random_char());
			if (i >= steady) begin
				burst--;
				if (burst == 0) begin
					char_bus.valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(negedge clk);
					burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 10);
				end
			end
		end
		char_bus.valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [COORD_W-1:0] cols, input logic [COORD_W-1:0] rows,
		input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg, input int count,
		input bit pressure);
		wait_idle();
		program_geometry(cols, rows, fg, bg);
		if (pressure)
			stall_requests++;
		send_stream(count, pressure ? STEADY_ITEMS : 0);
	endtask

	// Command sink: switch between always ready, random ready and a pulsed
	// pattern, each for a random stretch. A stall request from the stimulus
	// side holds ready low so the block backs up into chars.
	initial begin : cmd_sink
		sink_mode_t mode;
		int         mode_left;
		int         pulse_left;
		int         hold_left;
		logic       pulse_on;
		cmd_bus.ready = 1'b0;
		mode          = SINK_OPEN;
		mode_left     = 0;
		pulse_left    = 0;
		hold_left     = 0;
		pulse_on      = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && stall_served != stall_requests) begin
				stall_served = stall_requests;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				cmd_bus.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = sink_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					SINK_OPEN:   cmd_bus.ready <= 1'b1;
					SINK_RANDOM: cmd_bus.ready <= ($urandom_range(0, 3) != 0);
					default: begin
						if (pulse_left == 0) begin
							pulse_on   = !pulse_on;
							pulse_left = pulse_on ? $urandom_range(1, 4) : $urandom_range(1, 8);
						end
						pulse_left--;
						cmd_bus.ready <= pulse_on;
					end
				endcase
			end
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		arst_n             = 1'b0;
		char_bus.valid     = 1'b0;
		char_bus.char_code = '0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.reg_index  = REG_COLUMNS;
		cfg_bus.data       = '0;
		items_sent         = 0;
		settings_run       = 1;
		stall_requests     = 0;
		stall_served       = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed, on the reset grid of 80 x 25: both printable ends, a tab,
		// a return, a backspace that cannot move, a newline, a backspace that
		// wraps up to the end of the previous row, then codes that do nothing.
		directed_codes = '{8'd65, PRINT_LOW, PRINT_HIGH, CODE_TAB, CODE_RETURN,
			CODE_BACKSPACE, CODE_NEWLINE, CODE_BACKSPACE, 8'd0, 8'd127, 8'd128,
			8'd255, 8'd31};
		foreach (directed_codes[i])
			send_char(directed_codes[i]);
		char_bus.valid <= 1'b0;

		// Directed, on a 3 x 2 grid: wrap to a new line, wrap off the last row
		// into a scroll, a tab across the wrap, backspaces, a scrolling newline.
		wait_idle();
		program_geometry(8'd3, 8'd2, 24'($urandom), 24'($urandom));
		directed_codes = '{8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, CODE_TAB,
			CODE_BACKSPACE, CODE_NEWLINE, CODE_BACKSPACE};
		foreach (directed_codes[i])
			send_char(directed_codes[i]);
		char_bus.valid <= 1'b0;

		// Random part across geometries, colour extremes included.
		run_phase(8'd1, 8'd1, 24'hFFFFFF, 24'h000000, 40, 1'b0);
		run_phase(8'd255, 8'd255, 24'h000000, 24'hFFFFFF, 40, 1'b0);
		run_phase(8'd4, 8'd3, 24'($urandom), 24'($urandom), 70, 1'b0);
		run_phase(8'd0, 8'd0, 24'($urandom), 24'($urandom), 30, 1'b0);
		run_phase(8'd40, 8'd20, 24'($urandom), 24'($urandom), 40, 1'b0);
		// shrink under the cursor: it is most likely left outside the new grid
		run_phase(8'd3, 8'd2, 24'($urandom), 24'($urandom), 30, 1'b0);

		// Display off: characters are swallowed and the cursor must hold.
		wait_idle();
		write_reg(REG_ENABLE, {23'($urandom), 1'b0});
		cfg_bus.valid <= 1'b0;
		send_stream(20, 0);
		wait_idle();
		write_reg(REG_ENABLE, {23'($urandom), 1'b1});
		cfg_bus.valid <= 1'b0;

		// Long output stall while the input keeps offering.
		run_phase(8'd7, 8'd5, 24'($urandom), 24'($urandom), 80, 1'b1);

		for (int p = 0; p < 4; p++)
			run_phase(COORD_W'($urandom_range(2, 12)), COORD_W'($urandom_range(1, 6)),
				24'($urandom), 24'($urandom), 25, 1'b0);

		// Drain, then give stray commands a chance to show up.
		while (outstanding != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run covered %0d characters over %0d register settings,",
			items_sent, settings_run);
		$display("display off and a long output stall; checked %0d draw and %0d scroll",
			draws_checked, scrolls_checked);
		$display("commands, %0d mismatches.", errors);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin : watchdog
		#20_000_000;
		$display("Timed out with %0d commands still expected", outstanding);
		$display("Verification failed");
		$finish;
	end

endmodule
